[hdl/rrct_pkg.sv]
// Package for the round-robin completion-time block.
// Holds field widths, the sweep operation codes and the controller/datapath
// command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package rrct_pkg;

  localparam int unsigned SLICE_W     = 16;
  localparam int unsigned BURST_IN_W  = 16;
  localparam int unsigned CLOCK_W     = 20;
  localparam int unsigned TOTAL_W     = 24;
  localparam int unsigned INDEX_W     = 4;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd4;

  typedef enum logic [1:0] {
    SWEEP_SCAN,
    SWEEP_SKIP,
    SWEEP_PASS
  } sweep_op_e;

  typedef struct packed {
    logic      load;
    logic      job_init;
    logic      sweep_start;
    sweep_op_e sweep_op;
    logic      div_start;
    logic      latch_prod;
    logic      emit_init;
    logic      emit_rd;
    logic      emit_ld;
    logic      clr_job;
  } rrct_cmd_t;

  typedef struct packed {
    logic sweep_busy;
    logic div_busy;
    logic none_active;
    logic out_free;
    logic emit_last;
  } rrct_sts_t;

endpackage

[hdl/rrct_if.sv]
// Valid/ready channel interfaces for the round-robin completion-time block.
// Input items, result items and the time slice write channel.
// Depends on rrct_pkg.
`timescale 1ns / 1ps

interface rrct_in_if import rrct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BURST_IN_W-1:0] burst_cycles;
  logic                  last_process;

  modport source (output valid, output burst_cycles, output last_process, input ready);
  modport sink   (input valid, input burst_cycles, input last_process, output ready);
endinterface

interface rrct_out_if import rrct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] process_index;
  logic [CLOCK_W-1:0] completion_time;
  logic [CLOCK_W-1:0] wait_cycles;
  logic [TOTAL_W-1:0] total_wait;
  logic [TOTAL_W-1:0] total_turnaround;
  logic               last_result;

  modport source (output valid, output process_index, output completion_time,
                  output wait_cycles, output total_wait, output total_turnaround,
                  output last_result, input ready);
  modport sink   (input valid, input process_index, input completion_time,
                  input wait_cycles, input total_wait, input total_turnaround,
                  input last_result, output ready);
endinterface

interface rrct_cfg_if import rrct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLICE_W-1:0] time_slice;

  modport source (output valid, output time_slice, input ready);
  modport sink   (input valid, input time_slice, output ready);
endinterface

[hdl/rrct_div.sv]
// Iterative restoring divider that returns only the remainder.
// One dividend bit is retired per cycle. Depends on nothing.
`timescale 1ns / 1ps

module rrct_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW:0]   trial;
  logic [VW:0]   divisor_x;

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_x = {1'b0, divisor_i};
    trial     = {rem_q, quo_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so the trial fits.
      if (trial >= divisor_x) begin
        rem_d = VW'(trial - divisor_x);
      end else begin
        rem_d = trial[VW-1:0];
      end
      quo_d = {quo_q[DW-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[hdl/rrct_dp.sv]
// Datapath: burst, remaining and finish memories, the sweep sequencer,
// the service clock, the slice register and the result register.
// Depends on rrct_pkg, rrct_if and rrct_div.
`timescale 1ns / 1ps

module rrct_dp import rrct_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned BURST_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [BURST_IN_W-1:0] burst_i,
  input  rrct_cmd_t             cmd_i,
  output rrct_sts_t             sts_o,
  rrct_cfg_if.sink              cfg_if,
  rrct_out_if.source            out_if
);

  localparam int unsigned BW = BURST_BITS;
  localparam int unsigned SW = (BW > SLICE_W) ? BW : SLICE_W;
  localparam int unsigned NW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned IW = $clog2(MAX_PROCESSES);

  logic [BW-1:0]      burst_mem [MAX_PROCESSES];
  logic [BW-1:0]      rem_mem   [MAX_PROCESSES];
  logic [CLOCK_W-1:0] fin_mem   [MAX_PROCESSES];

  logic [SLICE_W-1:0] slice_q;
  logic [NW-1:0]      n_q;
  logic               sweep_busy_q;
  sweep_op_e          op_q;
  logic [NW-1:0]      rd_cnt_q;
  logic               pv_q;
  logic [IW-1:0]      pidx_q;
  logic [BW-1:0]      rem_rd_q;
  logic [NW-1:0]      active_q;
  logic [BW-1:0]      least_q;
  logic [BW-1:0]      lm1_q;
  logic [BW-1:0]      prod_q;
  logic [CLOCK_W-1:0] clock_q, clock_d;
  logic [IW-1:0]      eidx_q;
  logic [BW-1:0]      b_rd_q;
  logic [CLOCK_W-1:0] f_rd_q;
  logic [TOTAL_W-1:0] tw_q, tt_q;
  logic               out_valid_q;

  logic [BW-1:0]      burst_w;
  logic               room;
  logic               issue;
  logic               act;
  logic [SLICE_W-1:0] slice_eff;
  logic               gt;
  logic [SW-1:0]      inc;
  logic [BW-1:0]      rem_wd;
  logic               rem_we;
  logic               fin_we;
  logic               div_busy;
  logic [SLICE_W-1:0] div_rem;
  logic [CLOCK_W-1:0] comp;
  logic [CLOCK_W-1:0] wait_v;

  assign burst_w   = BW'(burst_i);
  assign room      = (n_q != NW'(MAX_PROCESSES));
  assign issue     = sweep_busy_q && (rd_cnt_q != n_q);
  assign act       = pv_q && (rem_rd_q != '0);
  assign slice_eff = (slice_q == '0) ? SLICE_W'(1) : slice_q;
  assign cfg_if.ready = 1'b1;

  // Per-entry update of the remaining time and the service clock.
  always_comb begin
    gt      = SW'(rem_rd_q) > SW'(slice_eff);
    inc     = '0;
    rem_wd  = '0;
    clock_d = clock_q;
    unique case (op_q)
      SWEEP_SKIP: begin
        rem_wd  = rem_rd_q - prod_q;
        clock_d = clock_q + CLOCK_W'(prod_q);
      end
      SWEEP_PASS: begin
        inc     = gt ? SW'(slice_eff) : SW'(rem_rd_q);
        rem_wd  = gt ? (rem_rd_q - BW'(slice_eff)) : '0;
        clock_d = clock_q + CLOCK_W'(inc);
      end
      default: begin
        clock_d = clock_q;
      end
    endcase
  end

  assign rem_we = act && (op_q != SWEEP_SCAN);
  assign fin_we = act && (op_q == SWEEP_PASS);

  rrct_div #(
    .DW (BW),
    .VW (SLICE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (least_q - BW'(1)),
    .divisor_i  (slice_eff),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      burst_mem[n_q[IW-1:0]] <= burst_w;
    end
    if (cmd_i.load && room) begin
      rem_mem[n_q[IW-1:0]] <= burst_w;
    end else if (rem_we) begin
      rem_mem[pidx_q] <= rem_wd;
    end
    if (fin_we) begin
      fin_mem[pidx_q] <= clock_d;
    end
    if (issue) begin
      rem_rd_q <= rem_mem[rd_cnt_q[IW-1:0]];
      pidx_q   <= rd_cnt_q[IW-1:0];
    end
    if (cmd_i.emit_rd) begin
      b_rd_q <= burst_mem[eidx_q];
      f_rd_q <= fin_mem[eidx_q];
    end
  end

  // Zero-burst processes never run and finish at time zero.
  assign comp   = (b_rd_q == '0) ? '0 : f_rd_q;
  assign wait_v = comp - CLOCK_W'(b_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q      <= SLICE_RESET;
      n_q          <= '0;
      sweep_busy_q <= 1'b0;
      op_q         <= SWEEP_SCAN;
      rd_cnt_q     <= '0;
      pv_q         <= 1'b0;
      active_q     <= '0;
      least_q      <= '0;
      lm1_q        <= '0;
      prod_q       <= '0;
      clock_q      <= '0;
      eidx_q       <= '0;
      tw_q         <= '0;
      tt_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        slice_q <= cfg_if.time_slice;
      end
      if (cmd_i.clr_job) begin
        n_q <= '0;
      end else if (cmd_i.load && room) begin
        n_q <= n_q + NW'(1);
      end

      pv_q <= issue;
      if (cmd_i.sweep_start) begin
        sweep_busy_q <= 1'b1;
        rd_cnt_q     <= '0;
        op_q         <= cmd_i.sweep_op;
      end else begin
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + NW'(1);
        end
        if (sweep_busy_q && !issue && !pv_q) begin
          sweep_busy_q <= 1'b0;
        end
      end

      if (cmd_i.sweep_start && (cmd_i.sweep_op == SWEEP_SCAN)) begin
        active_q <= '0;
      end else if (act && (op_q == SWEEP_SCAN)) begin
        active_q <= active_q + NW'(1);
        if ((active_q == '0) || (rem_rd_q < least_q)) begin
          least_q <= rem_rd_q;
        end
      end

      if (cmd_i.div_start) begin
        lm1_q <= least_q - BW'(1);
      end
      if (cmd_i.latch_prod) begin
        prod_q <= lm1_q - BW'(div_rem);
      end

      if (cmd_i.job_init) begin
        clock_q <= '0;
      end else if (rem_we) begin
        clock_q <= clock_d;
      end

      if (cmd_i.emit_init) begin
        eidx_q <= '0;
        tw_q   <= '0;
        tt_q   <= '0;
      end else if (cmd_i.emit_ld) begin
        eidx_q <= eidx_q + IW'(1);
        tw_q   <= tw_q + TOTAL_W'(wait_v);
        tt_q   <= tt_q + TOTAL_W'(comp);
      end

      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_if.process_index    <= INDEX_W'(eidx_q);
      out_if.completion_time  <= comp;
      out_if.wait_cycles      <= wait_v;
      out_if.total_wait       <= tw_q + TOTAL_W'(wait_v);
      out_if.total_turnaround <= tt_q + TOTAL_W'(comp);
      out_if.last_result      <= sts_o.emit_last;
    end
  end

  assign out_if.valid = out_valid_q;

  assign sts_o.sweep_busy  = sweep_busy_q;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.none_active = (active_q == '0);
  assign sts_o.out_free    = !out_valid_q || out_if.ready;
  assign sts_o.emit_last   = ((NW'(eidx_q) + NW'(1)) == n_q);

endmodule

[hdl/rrct_ctrl.sv]
// Controller state machine: load, scan/divide/skip/pass rounds, emission.
// Drives the datapath only through command and status structs.
// Depends on rrct_pkg.
`timescale 1ns / 1ps

module rrct_ctrl import rrct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  input  rrct_sts_t sts_i,
  output rrct_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_GO,
    ST_SCAN_W,
    ST_DIV_W,
    ST_SKIP_GO,
    ST_SKIP_W,
    ST_PASS_GO,
    ST_PASS_W,
    ST_EMIT_GO,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.job_init = 1'b1;
            state_d        = ST_SCAN_GO;
          end
        end
      end
      ST_SCAN_GO: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_op    = SWEEP_SCAN;
        state_d           = ST_SCAN_W;
      end
      ST_SCAN_W: begin
        if (!sts_i.sweep_busy) begin
          if (sts_i.none_active) begin
            state_d = ST_EMIT_GO;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV_W;
          end
        end
      end
      ST_DIV_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.latch_prod = 1'b1;
          state_d          = ST_SKIP_GO;
        end
      end
      ST_SKIP_GO: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_op    = SWEEP_SKIP;
        state_d           = ST_SKIP_W;
      end
      ST_SKIP_W: begin
        if (!sts_i.sweep_busy) begin
          state_d = ST_PASS_GO;
        end
      end
      ST_PASS_GO: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_op    = SWEEP_PASS;
        state_d           = ST_PASS_W;
      end
      ST_PASS_W: begin
        if (!sts_i.sweep_busy) begin
          state_d = ST_SCAN_GO;
        end
      end
      ST_EMIT_GO: begin
        cmd_o.emit_init = 1'b1;
        state_d         = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clr_job = 1'b1;
            state_d       = ST_LOAD;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/round_robin_completion_times_top.sv]
// Round-robin completion times: loads one burst time per cycle; after the flagged last item
// it runs R <= N rounds for N loaded processes before the first result is offered, each
// round made of one-entry-per-cycle memory sweeps and a bit-serial remainder step.
// Results leave one at a time, each after the one-port memory read before it, and emission
// waits while the previous result is not yet taken. Reset clears control state and sets
// time_slice to 4; memory contents are not cleared.
`timescale 1ns / 1ps

module round_robin_completion_times_top import rrct_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned BURST_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrct_in_if.sink     in_if,
  rrct_out_if.source  out_if,
  rrct_cfg_if.sink    cfg_if
);

  // Operation in brief. While loading, every accepted item writes its burst
  // time into both the burst memory and the remaining-time memory; items past
  // MAX_PROCESSES are dropped, but a last flag still ends the load. Then the
  // controller repeats rounds until no process is left with service time:
  //   scan  - one sweep finds the least nonzero remaining time and the count
  //           of active processes;
  //   skip  - the divider yields (least - 1) mod slice, so the datapath knows
  //           how much service every active process can take in whole passes
  //           before any of them finishes; one sweep subtracts it and advances
  //           the clock by it once per active process;
  //   pass  - one sweep gives every active process a slice or what it has
  //           left, advancing the clock and recording the finish time.
  // Each round finishes at least one process. Emission then reads burst and
  // finish time per process in load order and fills the result register,
  // with the running sums of waiting and turnaround time.
  // A new job may load as soon as the final result sits in the result register.

  rrct_cmd_t cmd;
  rrct_sts_t sts;
  logic      in_ready;

  rrct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_last_i  (in_if.last_process),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrct_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .BURST_BITS    (BURST_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .burst_i (in_if.burst_cycles),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .cfg_if  (cfg_if),
    .out_if  (out_if)
  );

  assign in_if.ready = in_ready;

`ifndef SYNTHESIS
  // The item that ends a job starts the rounds; no item is taken next.
  a_last_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && in_if.last_process |=> !in_if.ready)
    else $error("input taken right after the last item of a job");

  // While the result register holds a result that is not the final one of its
  // job, the controller is still emitting and loading stays closed.
  a_emit_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.last_result |-> !in_if.ready)
    else $error("input open while a job is still emitting");

  // A result that waits for the receiver stays offered and unchanged.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.completion_time)
      && $stable(out_if.process_index) && $stable(out_if.last_result))
    else $error("waiting result dropped or changed");
`endif

endmodule
